// ===== rtl/core/range_curve_mapper_assert.svh =====
// assertion macros for the range curve mapper
`ifndef RANGE_CURVE_MAPPER_ASSERT_SVH
`define RANGE_CURVE_MAPPER_ASSERT_SVH

// consequence must hold in the same cycle
`define RCM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence must hold in the following cycle
`define RCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rcm_pkg.sv =====
`default_nettype none

package rcm_pkg;

   localparam int unsigned FRAC_BITS = 16;
   localparam int unsigned QB        = 30;
   localparam int unsigned T_W       = FRAC_BITS + 1;
   localparam int unsigned INT_W     = $clog2(FRAC_BITS + 1);
   localparam int unsigned LOG_W     = INT_W + QB;
   localparam int unsigned EXP_W     = 16;
   localparam int unsigned EXP_FRAC  = 8;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [1:0] STATUS_INSIDE = 2'd0;
   localparam logic [1:0] STATUS_ABOVE  = 2'd1;
   localparam logic [1:0] STATUS_BELOW  = 2'd2;

   localparam logic [1:0] MODE_LINEAR  = 2'd0;
   localparam logic [1:0] MODE_ROOT    = 2'd1;
   localparam logic [1:0] MODE_EXP     = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_IN_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_MOD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURVE_EXP = 3'd5;

   typedef struct packed {
      logic [1:0]     status;
      logic           err;
      logic           empty;
      logic [T_W-1:0] t;
      logic [QB:0]    s_first;
   } rcm_side_type;

   function automatic logic [63:0] isqrt_const(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] rem;
      logic [63:0] bv;
      res = '0;
      rem = x;
      bv  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bv) begin
            rem = rem - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // 2^(-2^-k) in Q.30
   function automatic logic [QB-1:0] exp_root(input int k);
      logic [63:0] r;
      r = 64'd1 << (QB - 1);
      for (int j = 0; j < k; j++) begin
         r = isqrt_const(r << QB);
      end
      return r[QB-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rcm_log2_pipe.sv =====
`default_nettype none

module rcm_log2_pipe
   import rcm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  rcm_side_type     in_side,
   output logic             out_valid,
   output rcm_side_type     out_side,
   output logic [LOG_W-1:0] out_neg_log
);

   logic             valid_ff [0:QB+1];
   rcm_side_type     side_ff  [0:QB+1];
   logic [QB:0]      x_ff     [0:QB];
   logic [INT_W-1:0] int_ff   [0:QB];
   logic [QB-1:0]    frac_ff  [0:QB];
   logic [LOG_W-1:0] log_ff;
   logic [INT_W-1:0] lead;
   logic [QB:0]      x_norm;

   // leading one and normalisation into [1,2)
   always_comb begin
      lead = '0;
      for (int b = 1; b < T_W; b++) begin
         if (in_side.t[b]) lead = INT_W'(b);
      end
      x_norm = (QB+1)'(in_side.t) << (QB - int'(lead));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         side_ff[0]  <= in_side;
         x_ff[0]     <= x_norm;
         int_ff[0]   <= INT_W'(FRAC_BITS) - lead;
         frac_ff[0]  <= '0;
      end
   end

   // one squaring per stage, one fraction bit each
   for (genvar i = 1; i <= QB; i++) begin : g_sq
      logic [2*QB+1:0] sq;
      logic [QB+1:0]   y;
      assign sq = (2*QB+2)'(x_ff[i-1]) * (2*QB+2)'(x_ff[i-1]);
      assign y  = sq[2*QB+1:QB];
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (advance) begin
            valid_ff[i] <= valid_ff[i-1];
            side_ff[i]  <= side_ff[i-1];
            int_ff[i]   <= int_ff[i-1];
            if (y[QB+1]) begin
               x_ff[i]    <= y[QB+1:1];
               frac_ff[i] <= frac_ff[i-1] | (QB'(1) << (QB - i));
            end else begin
               x_ff[i]    <= y[QB:0];
               frac_ff[i] <= frac_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[QB+1] <= 1'b0;
      end else if (advance) begin
         valid_ff[QB+1] <= valid_ff[QB];
         side_ff[QB+1]  <= side_ff[QB];
         log_ff         <= {int_ff[QB], QB'(0)} - LOG_W'(frac_ff[QB]);
      end
   end

   assign out_valid   = valid_ff[QB+1];
   assign out_side    = side_ff[QB+1];
   assign out_neg_log = log_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rcm_exp2_pipe.sv =====
`default_nettype none

module rcm_exp2_pipe
   import rcm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  rcm_side_type     in_side,
   input  logic [LOG_W-1:0] in_arg,
   output logic             out_valid,
   output rcm_side_type     out_side,
   output logic [QB:0]      out_pow
);

   logic             valid_ff [0:QB+1];
   rcm_side_type     side_ff  [0:QB+1];
   logic [QB:0]      acc_ff   [0:QB];
   logic [QB-1:0]    f_ff     [0:QB];
   logic [INT_W-1:0] n_ff     [0:QB];
   logic             zero_ff  [0:QB];
   logic [QB:0]      pow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
         side_ff[0]  <= in_side;
         acc_ff[0]   <= (QB+1)'(1) << QB;
         f_ff[0]     <= in_arg[QB-1:0];
         n_ff[0]     <= in_arg[LOG_W-1:QB];
         zero_ff[0]  <= in_arg[LOG_W-1:QB] > INT_W'(QB);
      end
   end

   // one root factor per stage
   for (genvar k = 1; k <= QB; k++) begin : g_mul
      localparam logic [QB-1:0] ROOT_K = exp_root(k);
      logic [2*QB:0] prod;
      assign prod = (2*QB+1)'(acc_ff[k-1]) * (2*QB+1)'(ROOT_K);
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_ff[k-1];
            side_ff[k]  <= side_ff[k-1];
            f_ff[k]     <= f_ff[k-1];
            n_ff[k]     <= n_ff[k-1];
            zero_ff[k]  <= zero_ff[k-1];
            if (f_ff[k-1][QB-k]) begin
               acc_ff[k] <= prod[2*QB:QB];
            end else begin
               acc_ff[k] <= acc_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[QB+1] <= 1'b0;
      end else if (advance) begin
         valid_ff[QB+1] <= valid_ff[QB];
         side_ff[QB+1]  <= side_ff[QB];
         pow_ff         <= zero_ff[QB] ? '0 : (acc_ff[QB] >> n_ff[QB]);
      end
   end

   assign out_valid = valid_ff[QB+1];
   assign out_side  = side_ff[QB+1];
   assign out_pow   = pow_ff;

endmodule

`default_nettype wire

// ===== rtl/core/range_curve_mapper.sv =====
// range_curve_mapper: maps signed Q16.16 samples from a configured input
// range onto an output range through a linear, root power or exponential
// curve, with clamping flags and saturation.
// Channels: req_ (sample in) and rsp_ (result out) use valid and stall; a
// transfer happens on a rising edge with valid high and stall low. The
// csr_ port writes a register by index on valid with ready, which is
// always high; the user must write only while no sample is in flight,
// which the block does not enforce. From the req_ transfer a sample
// passes a fixed chain of stages: input check, a 17 stage divider for
// the normalised value, 32 stages of log2 by squaring, a 36 stage
// divider and scaler for the exponent, two 32 stage 2^-x units and three
// output stages. Throughput: one sample per cycle unless rsp_ stalls.
// A stall on rsp_ with a result waiting freezes the whole pipeline and
// raises req_stall in the same cycle; nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and restores the register
// defaults.
`default_nettype none

`include "range_curve_mapper_assert.svh"

module range_curve_mapper
   import rcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_sample_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_mapped_value,
   output logic [1:0]           rsp_range_status,
   output logic                 rsp_mode_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic signed [31:0] in_low_ff, in_high_ff, out_low_ff, out_high_ff;
   logic [1:0]         curve_mode_ff;
   logic [EXP_W-1:0]   curve_exp_ff;
   logic [31:0]        den_ff;
   logic [EXP_W-1:0]   e_eff_ff;
   logic [32:0]        mag_ff;
   logic               dneg_ff;
   logic               advance;

   assign csr_ready = 1'b1;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_low_ff     <= 32'sd0;
         in_high_ff    <= 32'sd65536;
         out_low_ff    <= 32'sd0;
         out_high_ff   <= 32'sd65536;
         curve_mode_ff <= MODE_LINEAR;
         curve_exp_ff  <= EXP_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IN_LOW:    in_low_ff     <= csr_data;
            REG_IN_HIGH:   in_high_ff    <= csr_data;
            REG_OUT_LOW:   out_low_ff    <= csr_data;
            REG_OUT_HIGH:  out_high_ff   <= csr_data;
            REG_CURVE_MOD: curve_mode_ff <= csr_data[1:0];
            REG_CURVE_EXP: curve_exp_ff  <= csr_data[EXP_W-1:0];
            default: ;
         endcase
      end
   end

   // values derived from the registers, settled long before a sample needs them
   logic signed [32:0] d_out;
   assign d_out = 33'(out_high_ff) - 33'(out_low_ff);

   always_ff @(posedge clock) begin
      den_ff   <= 32'(in_high_ff - in_low_ff);
      e_eff_ff <= (curve_exp_ff == '0) ? EXP_W'(1) : curve_exp_ff;
      dneg_ff  <= d_out[32];
      mag_ff   <= d_out[32] ? 33'(-d_out) : 33'(d_out);
   end

   // input check
   logic         above, below;
   rcm_side_type side_new;
   logic         in_valid_ff;
   rcm_side_type in_side_ff;
   logic [31:0]  in_num_ff;

   assign above = req_sample_value > in_high_ff;
   assign below = req_sample_value < in_low_ff;

   always_comb begin
      side_new         = '0;
      side_new.status  = above ? STATUS_ABOVE : (below ? STATUS_BELOW : STATUS_INSIDE);
      side_new.err     = !above && !below && (curve_mode_ff == MODE_INVALID);
      side_new.empty   = in_high_ff == in_low_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
         in_side_ff  <= side_new;
         in_num_ff   <= 32'(req_sample_value - in_low_ff);
      end
   end

   // normalised value t, one quotient bit per stage
   logic           td_valid_ff [0:FRAC_BITS];
   rcm_side_type   td_side_ff  [0:FRAC_BITS];
   logic [31:0]    td_rem_ff   [0:FRAC_BITS];
   logic [T_W-1:0] td_quo_ff   [0:FRAC_BITS];
   logic           td_ge0;

   assign td_ge0 = in_num_ff >= den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         td_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         td_valid_ff[0] <= in_valid_ff;
         td_side_ff[0]  <= in_side_ff;
         td_rem_ff[0]   <= td_ge0 ? in_num_ff - den_ff : in_num_ff;
         td_quo_ff[0]   <= T_W'(td_ge0) << FRAC_BITS;
      end
   end

   for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_tdiv
      logic [32:0] rem2;
      logic        ge;
      assign rem2 = {td_rem_ff[j-1], 1'b0};
      assign ge   = rem2 >= {1'b0, den_ff};
      always_ff @(posedge clock) begin
         if (reset) begin
            td_valid_ff[j] <= 1'b0;
         end else if (advance) begin
            td_valid_ff[j] <= td_valid_ff[j-1];
            td_side_ff[j]  <= td_side_ff[j-1];
            td_rem_ff[j]   <= ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
            td_quo_ff[j]   <= td_quo_ff[j-1] | (T_W'(ge) << (FRAC_BITS - j));
         end
      end
   end

   rcm_side_type     log_side_in;
   logic             log_valid;
   rcm_side_type     log_side;
   logic [LOG_W-1:0] log_val;

   always_comb begin
      log_side_in   = td_side_ff[FRAC_BITS];
      log_side_in.t = td_quo_ff[FRAC_BITS];
   end

   rcm_log2_pipe u_log (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (td_valid_ff[FRAC_BITS]),
      .in_side     (log_side_in),
      .out_valid   (log_valid),
      .out_side    (log_side),
      .out_neg_log (log_val)
   );

   // exponent scaling: divide by e for root power, multiply for exponential
   logic             sc_valid_ff [0:LOG_W];
   rcm_side_type     sc_side_ff  [0:LOG_W];
   logic [LOG_W-1:0] sc_a_ff     [0:LOG_W];
   logic [EXP_W-1:0] sc_rem_ff   [0:LOG_W];
   logic [LOG_W-1:0] sc_quo_ff   [0:LOG_W];
   logic [LOG_W-1:0] sc_alt_ff   [0:LOG_W];
   logic             sc_sat_ff   [0:LOG_W];
   logic [LOG_W+EXP_W-1:0] sc_prod;
   logic [LOG_W-1:0]       sc_alt_new;

   assign sc_prod = (LOG_W+EXP_W)'(log_val) * (LOG_W+EXP_W)'(e_eff_ff);
   assign sc_alt_new = (|sc_prod[LOG_W+EXP_W-1:LOG_W+EXP_FRAC]) ? '1 :
                       sc_prod[LOG_W+EXP_FRAC-1:EXP_FRAC];

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         sc_valid_ff[0] <= log_valid;
         sc_side_ff[0]  <= log_side;
         sc_a_ff[0]     <= log_val;
         sc_rem_ff[0]   <= EXP_W'(log_val[LOG_W-1:LOG_W-EXP_FRAC]);
         sc_quo_ff[0]   <= '0;
         sc_alt_ff[0]   <= sc_alt_new;
         sc_sat_ff[0]   <= EXP_W'(log_val[LOG_W-1:LOG_W-EXP_FRAC]) >= e_eff_ff;
      end
   end

   for (genvar i = 1; i <= LOG_W; i++) begin : g_sdiv
      localparam int XI = LOG_W - i;
      logic             xb;
      logic [EXP_W:0]   rem2;
      logic             ge;
      if (XI >= EXP_FRAC) begin : g_bit
         assign xb = sc_a_ff[i-1][XI-EXP_FRAC];
      end else begin : g_zero
         assign xb = 1'b0;
      end
      assign rem2 = {sc_rem_ff[i-1], xb};
      assign ge   = rem2 >= {1'b0, e_eff_ff};
      always_ff @(posedge clock) begin
         if (reset) begin
            sc_valid_ff[i] <= 1'b0;
         end else if (advance) begin
            sc_valid_ff[i] <= sc_valid_ff[i-1];
            sc_side_ff[i]  <= sc_side_ff[i-1];
            sc_a_ff[i]     <= sc_a_ff[i-1];
            sc_alt_ff[i]   <= sc_alt_ff[i-1];
            sc_sat_ff[i]   <= sc_sat_ff[i-1];
            sc_rem_ff[i]   <= ge ? EXP_W'(rem2 - {1'b0, e_eff_ff}) : EXP_W'(rem2);
            sc_quo_ff[i]   <= sc_quo_ff[i-1] | (LOG_W'(ge) << XI);
         end
      end
   end

   logic [LOG_W-1:0] exa_arg;
   logic             exa_valid;
   rcm_side_type     exa_side;
   logic [QB:0]      exa_pow;
   rcm_side_type     exb_side_in;
   logic [LOG_W-1:0] exb_arg;
   logic             exb_valid;
   rcm_side_type     exb_side;
   logic [QB:0]      exb_pow;

   assign exa_arg = (curve_mode_ff == MODE_EXP) ? sc_alt_ff[LOG_W] :
                    (sc_sat_ff[LOG_W] ? '1 : sc_quo_ff[LOG_W]);

   rcm_exp2_pipe u_exp_a (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sc_valid_ff[LOG_W]),
      .in_side   (sc_side_ff[LOG_W]),
      .in_arg    (exa_arg),
      .out_valid (exa_valid),
      .out_side  (exa_side),
      .out_pow   (exa_pow)
   );

   always_comb begin
      exb_side_in         = exa_side;
      exb_side_in.s_first = exa_pow;
   end

   // 2^s - 1 formed as 2 * 2^-(1-s) - 1
   assign exb_arg = (LOG_W'(1) << QB) - LOG_W'(exa_pow);

   rcm_exp2_pipe u_exp_b (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (exa_valid),
      .in_side   (exb_side_in),
      .in_arg    (exb_arg),
      .out_valid (exb_valid),
      .out_side  (exb_side),
      .out_pow   (exb_pow)
   );

   // round the shaped value to Q1.16 and cap at one; a slightly negative
   // exponential result wraps and then rounds to zero or caps
   logic [QB+1:0]  two_s2;
   logic [QB+1:0]  s_val;
   logic [QB+1:0]  s_round;
   logic [QB+1:0]  s_shift;
   logic [T_W-1:0] shaped;
   logic           rd_valid_ff;
   rcm_side_type   rd_side_ff;
   logic [T_W-1:0] rd_shaped_ff;

   assign two_s2  = {exb_pow, 1'b0};
   assign s_val   = (curve_mode_ff == MODE_EXP) ? two_s2 - ((QB+2)'(1) << QB)
                                                : (QB+2)'(exb_side.s_first);
   assign s_round = s_val + ((QB+2)'(1) << (QB - 1 - FRAC_BITS));
   assign s_shift = s_round >> (QB - FRAC_BITS);

   always_comb begin
      if (curve_mode_ff == MODE_LINEAR || exb_side.t == '0) begin
         shaped = exb_side.t;
      end else if (s_shift > ((QB+2)'(1) << FRAC_BITS)) begin
         shaped = T_W'(1) << FRAC_BITS;
      end else begin
         shaped = s_shift[T_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (advance) begin
         rd_valid_ff  <= exb_valid;
         rd_side_ff   <= exb_side;
         rd_shaped_ff <= shaped;
      end
   end

   // scale onto the output span
   logic [T_W+32:0] mu_prod;
   logic [T_W+32:0] mu_sum;
   logic            mu_valid_ff;
   rcm_side_type    mu_side_ff;
   logic [33:0]     mu_q_ff;

   assign mu_prod = (T_W+33)'(rd_shaped_ff) * (T_W+33)'(mag_ff);
   assign mu_sum  = mu_prod + ((T_W+33)'(1) << (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else if (advance) begin
         mu_valid_ff <= rd_valid_ff;
         mu_side_ff  <= rd_side_ff;
         mu_q_ff     <= mu_sum[FRAC_BITS+33:FRAC_BITS];
      end
   end

   // offset, saturate and pick the result class
   logic signed [35:0] res_wide;
   logic signed [31:0] res_sat;
   logic signed [31:0] res_sel;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_err_ff;

   assign res_wide = dneg_ff ? 36'(out_low_ff) - $signed({2'b00, mu_q_ff})
                             : 36'(out_low_ff) + $signed({2'b00, mu_q_ff});

   always_comb begin
      if (res_wide > 36'sd2147483647) begin
         res_sat = 32'sh7fffffff;
      end else if (res_wide < -36'sd2147483648) begin
         res_sat = 32'sh80000000;
      end else begin
         res_sat = res_wide[31:0];
      end
   end

   always_comb begin
      priority if (mu_side_ff.status == STATUS_ABOVE) begin
         res_sel = out_high_ff;
      end else if (mu_side_ff.status == STATUS_BELOW) begin
         res_sel = out_low_ff;
      end else if (mu_side_ff.err) begin
         res_sel = '0;
      end else if (mu_side_ff.empty) begin
         res_sel = out_low_ff;
      end else begin
         res_sel = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff  <= mu_valid_ff;
         rsp_value_ff  <= res_sel;
         rsp_status_ff <= mu_side_ff.status;
         rsp_err_ff    <= mu_side_ff.err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_value = rsp_value_ff;
   assign rsp_range_status = rsp_status_ff;
   assign rsp_mode_error   = rsp_err_ff;

   `RCM_ASSERT_SAME(a_clamp_no_err, clock, reset, rsp_valid_ff && rsp_status_ff != STATUS_INSIDE, !rsp_err_ff, "clamped result flags a mode error")
   `RCM_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid_ff && rsp_err_ff, rsp_value_ff == 32'sd0 && rsp_status_ff == STATUS_INSIDE, "mode error result not zero inside")
   `RCM_ASSERT_SAME(a_stall_back, clock, reset, rsp_valid_ff && rsp_stall, req_stall, "input not held while result waits")
   `RCM_ASSERT_NEXT(a_out_load, clock, reset, mu_valid_ff && advance, rsp_valid_ff, "last stage lost on transfer to output")

endmodule

`default_nettype wire

// ===== tb/sv/tb_range_curve_mapper.sv =====
`default_nettype none

module tb_range_curve_mapper;
   import rcm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES = 170;
   localparam longint unsigned Q_ONE = 64'd1 << QB;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

   typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               err;
   } map_result_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_TYPED, ROW_PREDICT} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [2:0]         index;
      logic signed [31:0] data;
      logic signed [31:0] sample;
      logic signed [31:0] value;
      logic [1:0]         status;
      logic               err;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [31:0]   req_sample_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic signed [31:0]   rsp_mapped_value;
   logic [1:0]           rsp_range_status;
   logic                 rsp_mode_error;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_data = '0;

   logic signed [31:0] cur_in_low, cur_in_high, cur_out_low, cur_out_high;
   logic [1:0]         cur_mode;
   logic [15:0]        cur_exponent;

   map_result_type pending_results[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   bit          quiet_phase = 0;
   int unsigned stall_left = 0;

   range_curve_mapper dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res, bv;
      res = 0;
      bv = 64'd1 << 62;
      while (bv > x) bv >>= 2;
      while (bv != 0) begin
         if (x >= res + bv) begin
            x -= res + bv;
            res = (res >> 1) + bv;
         end else begin
            res >>= 1;
         end
         bv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned neg_log_t(input longint unsigned t);
      int m;
      longint unsigned x, frac;
      m = 0;
      frac = 0;
      while (m < 63 && (t >> (m + 1)) != 0) m++;
      x = t << (QB - m);
      for (int i = 0; i < QB; i++) begin
         x = (x * x) >> QB;
         if (x >= (Q_ONE << 1)) begin
            x >>= 1;
            frac |= 64'd1 << (QB - 1 - i);
         end
      end
      return (longint'(FRAC_BITS - m) << QB) - frac;
   endfunction

   function automatic longint unsigned pow2_neg(input longint unsigned a);
      longint unsigned n, f, acc, r;
      n = a >> QB;
      f = a & (Q_ONE - 1);
      acc = Q_ONE;
      r = Q_ONE >> 1;
      if (n > QB) return 0;
      for (int k = 1; k <= QB; k++) begin
         r = int_sqrt(r << QB);
         if ((f >> (QB - k)) & 1) acc = (acc * r) >> QB;
      end
      return acc >> n;
   endfunction

   function automatic map_result_type map_sample(input logic signed [31:0] sample);
      map_result_type r;
      longint v, lo, hi, olo, ohi, d, res;
      longint unsigned t, shaped, e, q, mag, a, s, tone;
      v = sample;
      lo = cur_in_low;
      hi = cur_in_high;
      olo = cur_out_low;
      ohi = cur_out_high;
      tone = 64'd1 << FRAC_BITS;
      r.status = STATUS_INSIDE;
      r.err = 1'b0;
      if (v > hi) begin
         res = ohi;
         r.status = STATUS_ABOVE;
      end else if (v < lo) begin
         res = olo;
         r.status = STATUS_BELOW;
      end else if (cur_mode == MODE_INVALID) begin
         res = 0;
         r.err = 1'b1;
      end else if (hi == lo) begin
         res = olo;
      end else begin
         t = (longint'(v - lo) << FRAC_BITS) / longint'(hi - lo);
         if (t > tone) t = tone;
         e = (cur_exponent != 0) ? cur_exponent : 1;
         if (cur_mode == MODE_LINEAR || t == 0) begin
            shaped = t;
         end else begin
            a = neg_log_t(t);
            if (cur_mode == MODE_ROOT) begin
               s = pow2_neg((a << 8) / e);
            end else begin
               s = pow2_neg((a * e) >> 8);
               s = 2 * pow2_neg(Q_ONE - s) - Q_ONE;
            end
            shaped = (s + (64'd1 << (QB - 1 - FRAC_BITS))) >> (QB - FRAC_BITS);
            if (shaped > tone) shaped = tone;
         end
         d = ohi - olo;
         mag = (d < 0) ? -d : d;
         q = (shaped * mag + (tone >> 1)) >> FRAC_BITS;
         res = (d < 0) ? olo - longint'(q) : olo + longint'(q);
         if (res > longint'(S32_MAX)) res = S32_MAX;
         if (res < longint'(S32_MIN)) res = S32_MIN;
      end
      r.value = res[31:0];
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (quiet_phase || p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // stall pattern on the result side
   always @(posedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 4);
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   // check results and watch for a hang, sampled mid-cycle
   always @(negedge clock) begin
      map_result_type want;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_range_curve_mapper: FAIL");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transfer: value %0d status %0d err %0b",
                           rsp_mapped_value, rsp_range_status, rsp_mode_error);
            end else begin
               want = pending_results.pop_front();
               if (rsp_mapped_value !== want.value || rsp_range_status !== want.status
                   || rsp_mode_error !== want.err) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: expected %0d/%0d/%0b actual %0d/%0d/%0b",
                              want.value, want.status, want.err, rsp_mapped_value,
                              rsp_range_status, rsp_mode_error);
               end
            end
         end
      end
   end

   task automatic wait_idle();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      case (index)
         REG_IN_LOW:    cur_in_low = data;
         REG_IN_HIGH:   cur_in_high = data;
         REG_OUT_LOW:   cur_out_low = data;
         REG_OUT_HIGH:  cur_out_high = data;
         REG_CURVE_MOD: cur_mode = data[1:0];
         REG_CURVE_EXP: cur_exponent = data[15:0];
         default: ;
      endcase
   endtask

   task automatic send_sample(input logic signed [31:0] sample, input map_result_type want);
      int unsigned gap;
      bit ok;
      csr_valid <= 1'b0;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_value <= sample;
      pending_results.push_back(want);
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
   endtask

   function automatic logic [31:0] pick_bound();
      case ($urandom_range(0, 5))
         0: return S32_MIN;
         1: return S32_MAX;
         2: return $urandom;
         default: return $signed($urandom_range(0, 400000)) - 200000;
      endcase
   endfunction

   function automatic logic [15:0] pick_exponent();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return 16'hffff;
         2: return 16'd256;
         3: return $urandom_range(1, 65535);
         default: return $urandom_range(32, 2048);
      endcase
   endfunction

   function automatic logic signed [31:0] pick_sample();
      longint span;
      longint unsigned off;
      span = longint'(cur_in_high) - longint'(cur_in_low);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return cur_in_low;
         2: return cur_in_high;
         3: return ($urandom_range(0, 1) == 0) ? cur_in_high + 1 : cur_in_low - 1;
         default: begin
            if (span < 0) return $urandom;
            off = {$urandom, $urandom};
            off = off % longint'(span + 1);
            return cur_in_low + off[31:0];
         end
      endcase
   endfunction

   task automatic random_phase(input int unsigned count);
      logic [31:0] b0, b1;
      wait_idle();
      b0 = pick_bound();
      b1 = pick_bound();
      if ($urandom_range(0, 9) < 8 && $signed(b0) > $signed(b1)) begin
         write_reg(REG_IN_LOW, b1);
         write_reg(REG_IN_HIGH, b0);
      end else begin
         write_reg(REG_IN_LOW, b0);
         write_reg(REG_IN_HIGH, ($urandom_range(0, 9) == 0) ? b0 : b1);
      end
      write_reg(REG_OUT_LOW, pick_bound());
      write_reg(REG_OUT_HIGH, pick_bound());
      write_reg(REG_CURVE_MOD, ($urandom_range(0, 9) == 0) ? MODE_INVALID
                                                          : $urandom_range(0, 2));
      write_reg(REG_CURVE_EXP, pick_exponent());
      if ($urandom_range(0, 7) == 0) write_reg(3'd7, $urandom);
      quiet_phase = ($urandom_range(0, 4) == 0);
      repeat (count) begin
         logic signed [31:0] sample;
         sample = pick_sample();
         send_sample(sample, map_sample(sample));
      end
   endtask

   stim_row_type directed_rows[] = '{
      '{ROW_TYPED,   0, 0, 32'sd0, 32'sd0, STATUS_INSIDE, 1'b0},
      '{ROW_TYPED,   0, 0, 32'sd65536, 32'sd65536, STATUS_INSIDE, 1'b0},
      '{ROW_TYPED,   0, 0, 32'sd32768, 32'sd32768, STATUS_INSIDE, 1'b0},
      '{ROW_TYPED,   0, 0, 32'sd65537, 32'sd65536, STATUS_ABOVE, 1'b0},
      '{ROW_TYPED,   0, 0, -32'sd1, 32'sd0, STATUS_BELOW, 1'b0},
      '{ROW_TYPED,   0, 0, S32_MAX, 32'sd65536, STATUS_ABOVE, 1'b0},
      '{ROW_TYPED,   0, 0, S32_MIN, 32'sd0, STATUS_BELOW, 1'b0},
      '{ROW_CSR, REG_CURVE_MOD, MODE_INVALID, 0, 0, 0, 0},
      '{ROW_TYPED,   0, 0, 32'sd100, 32'sd0, STATUS_INSIDE, 1'b1},
      '{ROW_TYPED,   0, 0, 32'sd70000, 32'sd65536, STATUS_ABOVE, 1'b0},
      '{ROW_CSR, REG_CURVE_MOD, MODE_ROOT, 0, 0, 0, 0},
      '{ROW_CSR, REG_CURVE_EXP, 32'd512, 0, 0, 0, 0},
      '{ROW_PREDICT, 0, 0, 32'sd16384, 0, 0, 0},
      '{ROW_TYPED,   0, 0, 32'sd0, 32'sd0, STATUS_INSIDE, 1'b0},
      '{ROW_PREDICT, 0, 0, 32'sd65536, 0, 0, 0},
      '{ROW_CSR, REG_CURVE_MOD, MODE_EXP, 0, 0, 0, 0},
      '{ROW_CSR, REG_CURVE_EXP, 32'hffff, 0, 0, 0, 0},
      '{ROW_PREDICT, 0, 0, 32'sd40000, 0, 0, 0},
      '{ROW_TYPED,   0, 0, 32'sd0, 32'sd0, STATUS_INSIDE, 1'b0},
      '{ROW_CSR, REG_CURVE_EXP, 32'd1, 0, 0, 0, 0},
      '{ROW_PREDICT, 0, 0, 32'sd40000, 0, 0, 0},
      '{ROW_CSR, REG_IN_HIGH, 32'd0, 0, 0, 0, 0},
      '{ROW_TYPED,   0, 0, 32'sd0, 32'sd0, STATUS_INSIDE, 1'b0},
      '{ROW_CSR, REG_IN_LOW, S32_MIN, 0, 0, 0, 0},
      '{ROW_CSR, REG_IN_HIGH, S32_MAX, 0, 0, 0, 0},
      '{ROW_CSR, REG_OUT_LOW, S32_MIN, 0, 0, 0, 0},
      '{ROW_CSR, REG_OUT_HIGH, S32_MAX, 0, 0, 0, 0},
      '{ROW_CSR, REG_CURVE_MOD, MODE_LINEAR, 0, 0, 0, 0},
      '{ROW_TYPED,   0, 0, S32_MIN, S32_MIN, STATUS_INSIDE, 1'b0},
      '{ROW_PREDICT, 0, 0, S32_MAX, 0, 0, 0},
      '{ROW_PREDICT, 0, 0, 32'sd0, 0, 0, 0},
      '{ROW_CSR, REG_IN_LOW, 32'd10, 0, 0, 0, 0},
      '{ROW_CSR, REG_IN_HIGH, 32'd5, 0, 0, 0, 0},
      '{ROW_TYPED,   0, 0, 32'sd7, S32_MAX, STATUS_ABOVE, 1'b0}
   };

   initial begin
      map_result_type want;
      cur_in_low = 0;
      cur_in_high = 65536;
      cur_out_low = 0;
      cur_out_high = 65536;
      cur_mode = MODE_LINEAR;
      cur_exponent = 16'd256;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            if (directed_rows[i].kind == ROW_TYPED) begin
               want.value = directed_rows[i].value;
               want.status = directed_rows[i].status;
               want.err = directed_rows[i].err;
            end else begin
               want = map_sample(directed_rows[i].sample);
            end
            send_sample(directed_rows[i].sample, want);
         end
      end

      repeat (20) random_phase($urandom_range(50, 105));
      random_phase(40);

      wait_idle();
      quiet_phase = 1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_range_curve_mapper: PASS");
      end else begin
         $display("tb_range_curve_mapper: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
